// ===== hdl/point_in_polygon_test_top_macros.svh =====
// Assertion macros for the point-in-polygon test block.
// Included by the top level; expects clk and rst in the including scope.
`ifndef POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_TEST_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pipt_pkg.sv =====
// Shared types, constants and helpers for the point-in-polygon test block.
// No dependencies; compiled before the interfaces and modules.
package pipt_pkg;

  localparam int FIELD_BITS = 32;                   // width of coordinate fields
  localparam int COORD_BITS = 32;                   // coordinate bits actually used
  localparam int DIFF_W     = COORD_BITS + 1;       // coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;           // one cross product term
  localparam int CROSS_W    = PROD_W + 1;           // difference of the two terms
  localparam int VERDICT_W  = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_BOUNDARY = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Result of one edge test, after the cross product is resolved.
  typedef struct packed {
    logic bnd;    // query lies on this edge
    logic flip;   // edge crosses the ray: toggle parity
  } edge_res_t;

  // Inclusive range check with the endpoints in either order.
  function automatic logic coord_between(coord_t p, coord_t a, coord_t b);
    coord_between = (p >= a && p <= b) || (p <= a && p >= b);
  endfunction

  // Low COORD_BITS of a field, as a signed coordinate.
  function automatic coord_t coord_of(logic [FIELD_BITS-1:0] v);
    coord_of = $signed(v[COORD_BITS-1:0]);
  endfunction

endpackage

// ===== hdl/pipt_req_if.sv =====
// Request channel of the point-in-polygon test block: one polygon vertex.
// Depends on pipt_pkg for field widths.
interface pipt_req_if;
  import pipt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] point_x;
  logic [FIELD_BITS-1:0] point_y;
  logic [FIELD_BITS-1:0] vertex_x;
  logic [FIELD_BITS-1:0] vertex_y;
  logic                  last_vertex;

  modport source (output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                  input ready);
  modport sink   (input valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
                  output ready);
endinterface

// ===== hdl/pipt_rsp_if.sv =====
// Result channel of the point-in-polygon test block: one verdict per polygon.
// Depends on pipt_pkg for the verdict width.
interface pipt_rsp_if;
  import pipt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// ===== hdl/point_in_polygon_test_top.sv =====
// Point-in-polygon test by crossing-number parity, vertex-streaming top level.
// Depends on pipt_pkg, pipt_req_if, pipt_rsp_if, pipt_edge and the macro header.
//
// Usage:
//   req carries one polygon vertex per request: vertex_x/vertex_y, the query
//   point (point_x/point_y, sampled only on the first vertex of a polygon) and
//   last_vertex, which closes the polygon. rsp returns one verdict per polygon
//   (boundary, inside, outside) when its last vertex has been processed.
//   Coordinates use the low COORD_BITS bits of each field, two's complement.
// Timing:
//   One request per cycle sustained unless rsp stalls. After the last
//   vertex is accepted, its verdict passes an input register, then a register
//   holding the cross product terms of both edges (four parallel multipliers),
//   then the result register. The per-polygon parity and boundary flags are
//   folded in at the last stage, so consecutive vertices never wait on each
//   other.
// Reset (rst, synchronous): all stages empty, no verdict pending, the block
//   waits for the first vertex of a new polygon.
// Stall: a held verdict only blocks a following last vertex; other vertices
//   keep flowing through. Once both stages back up, req.ready drops.
`include "point_in_polygon_test_top_macros.svh"

module point_in_polygon_test_top (
  input  logic clk,
  input  logic rst,
  pipt_req_if.sink   req,
  pipt_rsp_if.source rsp
);
  import pipt_pkg::*;

  // ---------------- stage 1: input register ----------------
  logic   s1_valid;
  coord_t s1_px, s1_py, s1_vx, s1_vy;
  logic   s1_last;

  // polygon context, updated as each request leaves stage 1
  logic   mid_polygon;
  coord_t query_x, query_y, first_x, first_y, prev_x, prev_y;

  // ---------------- stage 2: cross product terms ----------------
  logic      s2_valid;
  logic      s2_first;
  logic      s2_last;
  edge_res_t res_prev;   // edge from previous vertex to this one
  edge_res_t res_close;  // closing edge from this vertex back to the first

  // running polygon flags
  logic inside_parity, on_boundary;

  // ---------------- output register ----------------
  logic                 out_valid;
  logic [VERDICT_W-1:0] out_verdict;

  // handshake and advance
  logic   s1_first;
  logic   fire2, adv1, accept;
  coord_t cur_qx, cur_qy, cur_fx, cur_fy;
  logic   bnd_next, parity_next;

  // a retiring last vertex needs the result register; others retire freely
  assign fire2  = s2_valid && (!s2_last || !out_valid || rsp.ready);
  assign adv1   = s1_valid && (!s2_valid || fire2);
  assign accept = req.valid && req.ready;

  assign req.ready   = !s1_valid || adv1;
  assign rsp.valid   = out_valid;
  assign rsp.verdict = out_verdict;

  // first vertex supplies its own query point and first vertex
  always_comb begin
    s1_first = !mid_polygon;
    cur_qx   = s1_first ? s1_px : query_x;
    cur_qy   = s1_first ? s1_py : query_y;
    cur_fx   = s1_first ? s1_vx : first_x;
    cur_fy   = s1_first ? s1_vy : first_y;
  end

  pipt_edge u_edge_prev (
    .clk (clk),
    .en  (adv1),
    .ax  (prev_x),
    .ay  (prev_y),
    .bx  (s1_vx),
    .by  (s1_vy),
    .px  (cur_qx),
    .py  (cur_qy),
    .res (res_prev)
  );

  pipt_edge u_edge_close (
    .clk (clk),
    .en  (adv1),
    .ax  (s1_vx),
    .ay  (s1_vy),
    .bx  (cur_fx),
    .by  (cur_fy),
    .px  (cur_qx),
    .py  (cur_qy),
    .res (res_close)
  );

  // fold in this vertex's edges; a first vertex restarts the flags
  always_comb begin
    bnd_next    = (!s2_first && on_boundary)
                | (!s2_first && res_prev.bnd)
                | (s2_last && res_close.bnd);
    parity_next = (!s2_first && inside_parity)
                ^ (!s2_first && res_prev.flip)
                ^ (s2_last && res_close.flip);
  end

  // request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_px   <= coord_of(req.point_x);
      s1_py   <= coord_of(req.point_y);
      s1_vx   <= coord_of(req.vertex_x);
      s1_vy   <= coord_of(req.vertex_y);
      s1_last <= req.last_vertex;
    end
  end

  // polygon context and stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_polygon <= 1'b0;
      s2_valid    <= 1'b0;
      query_x     <= '0;
      query_y     <= '0;
      first_x     <= '0;
      first_y     <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
    end else begin
      if (adv1) begin
        s2_valid    <= 1'b1;
        mid_polygon <= !s1_last;
        prev_x      <= s1_vx;
        prev_y      <= s1_vy;
        if (s1_first) begin
          query_x <= s1_px;
          query_y <= s1_py;
          first_x <= s1_vx;
          first_y <= s1_vy;
        end
      end else if (fire2) begin
        s2_valid <= 1'b0;
      end
    end
    if (adv1) begin
      s2_first <= s1_first;
      s2_last  <= s1_last;
    end
  end

  // running flags and verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_parity <= 1'b0;
      on_boundary   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (fire2) begin
        inside_parity <= parity_next;
        on_boundary   <= bnd_next;
      end
      if (fire2 && s2_last) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire2 && s2_last) begin
      out_verdict <= bnd_next ? VERDICT_BOUNDARY :
                     (parity_next ? VERDICT_INSIDE : VERDICT_OUTSIDE);
    end
  end

  // ---------------- assertions ----------------
  `PIPT_ASSERT_IMP(a_stall_full, !req.ready, s1_valid && s2_valid, "ready low with a free stage")
  `PIPT_ASSERT_NXT(a_last_emits, fire2 && s2_last, out_valid, "closed polygon gave no verdict")
  `PIPT_ASSERT_IMP(a_verdict_code, out_valid, out_verdict <= VERDICT_OUTSIDE, "bad verdict code")

endmodule

// ===== hdl/pipt_edge.sv =====
// One edge test from A to B against query P: range/vertex flags and the two
// cross product terms are registered, then resolved. Depends on pipt_pkg.
module pipt_edge (
  input  logic               clk,
  input  logic               en,
  input  pipt_pkg::coord_t   ax,
  input  pipt_pkg::coord_t   ay,
  input  pipt_pkg::coord_t   bx,
  input  pipt_pkg::coord_t   by,
  input  pipt_pkg::coord_t   px,
  input  pipt_pkg::coord_t   py,
  output pipt_pkg::edge_res_t res
);
  import pipt_pkg::*;

  typedef struct packed {
    logic hit;
    logic horiz;
    logic inrange;
    logic skip;
    logic up;
  } edge_flags_t;

  edge_flags_t flags, flags_next;
  logic signed [PROD_W-1:0]  prod_a, prod_b;
  logic signed [PROD_W-1:0]  prod_a_next, prod_b_next;
  logic signed [DIFF_W-1:0]  dax, day, dbx, dby;
  logic signed [CROSS_W-1:0] cross_diff;
  logic                      cross_zero, cross_pos, consider;

  always_comb begin
    dax = DIFF_W'(ax) - DIFF_W'(px);
    day = DIFF_W'(ay) - DIFF_W'(py);
    dbx = DIFF_W'(bx) - DIFF_W'(px);
    dby = DIFF_W'(by) - DIFF_W'(py);
    prod_a_next = PROD_W'(dax) * PROD_W'(dby);
    prod_b_next = PROD_W'(dbx) * PROD_W'(day);

    flags_next.hit     = (px == ax && py == ay) || (px == bx && py == by);
    flags_next.horiz   = (ay == by) && (py == ay) && coord_between(px, ax, bx);
    flags_next.inrange = coord_between(py, ay, by);
    // half-open rule: skip when the ray passes through the lower endpoint
    flags_next.skip    = (py == ay && by >= ay) || (py == by && ay >= by);
    flags_next.up      = ay < by;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags  <= flags_next;
      prod_a <= prod_a_next;
      prod_b <= prod_b_next;
    end
  end

  always_comb begin
    cross_diff = CROSS_W'(prod_a) - CROSS_W'(prod_b);
    cross_zero = (cross_diff == '0);
    cross_pos  = !cross_diff[CROSS_W-1] && !cross_zero;
    consider   = !flags.hit && !flags.horiz && flags.inrange && !flags.skip;
    res.bnd    = flags.hit || flags.horiz || (consider && cross_zero);
    res.flip   = consider && !cross_zero && (flags.up == cross_pos);
  end

endmodule
